[design/snc_pkg.sv]
// Shared types, constants and the neighborhood classifier for the skeleton node classifier.
// Depends on nothing; imported by snc_line_store, skeleton_node_classifier_3x3 and the testbench.
`default_nettype none

package snc_pkg;

    // Default maximum padded image width (depth of the line store).
    localparam int MAX_WIDTH_DEF = 2048;

    // Configuration register widths and port widths.
    localparam int FRAME_W_W  = 12;
    localparam int FRAME_H_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Reset values of the frame size registers.
    localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
    localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RST = 16'd2048;

    // Output rank codes.
    typedef enum logic [2:0] {
        RANK_NONE      = 3'd0,
        RANK_ENDPOINT  = 3'd1,
        RANK_BRANCH    = 3'd2,
        RANK_JUNCTION3 = 3'd3,
        RANK_JUNCTION4 = 3'd4,
        RANK_HOLLOW    = 3'd5
    } rank_t;

    // Hit-or-miss masks; neighbor bit 7 is top-left, then clockwise to bit 0 (left).
    localparam logic [7:0] MASK_EDGES     = 8'b0101_0101;
    localparam logic [7:0] MASK_END_HIT   = 8'b0100_0000;
    localparam logic [7:0] MASK_END_MISS  = 8'b0001_1111;
    localparam logic [7:0] MASK_J3A_HIT   = 8'b1010_0100;
    localparam logic [7:0] MASK_J3A_MISSA = 8'b0101_0001;
    localparam logic [7:0] MASK_J3_MISSB  = 8'b0100_1010;
    localparam logic [7:0] MASK_J3B_HIT   = 8'b0001_0101;
    localparam logic [7:0] MASK_CORNERS   = 8'b1010_1010;
    localparam logic [7:0] MASK_J4_BLOCK  = 8'b0001_1100;

    // Rank of one window: center bit and its eight neighbors.
    function automatic rank_t classify(input logic center, input logic [7:0] nb);
        logic [15:0] dbl;
        logic [7:0]  rot;
        logic        found;
        rank_t       rank;
        dbl   = {nb, nb};
        found = 1'b0;
        rank  = RANK_BRANCH;
        if (!center) begin
            rank  = ((nb & MASK_EDGES) == MASK_EDGES) ? RANK_HOLLOW : RANK_NONE;
            found = 1'b1;
        end else if (nb == 8'd0) begin
            rank  = RANK_ENDPOINT;
            found = 1'b1;
        end
        // The eight rotations are tested in order; the first hit wins.
        for (int s = 0; s < 8; s++) begin
            rot = 8'((dbl << s) >> 8);
            if (!found) begin
                if (((rot & MASK_END_HIT) == MASK_END_HIT) &&
                    ((rot & MASK_END_MISS) == 8'd0)) begin
                    rank  = RANK_ENDPOINT;
                    found = 1'b1;
                end else if (((rot & MASK_J3A_HIT) == MASK_J3A_HIT) &&
                             (((rot & MASK_J3A_MISSA) == 8'd0) ||
                              ((rot & MASK_J3_MISSB) == 8'd0))) begin
                    rank  = RANK_JUNCTION3;
                    found = 1'b1;
                end else if (((rot & MASK_J3B_HIT) == MASK_J3B_HIT) &&
                             ((rot & MASK_J3_MISSB) == 8'd0)) begin
                    rank  = RANK_JUNCTION3;
                    found = 1'b1;
                end
            end
        end
        // Four-way junctions: a plus, a cross or a filled lower block.
        if (!found) begin
            if ((((nb & MASK_CORNERS) == MASK_CORNERS) && ((nb & MASK_EDGES) == 8'd0)) ||
                (((nb & MASK_EDGES) == MASK_EDGES) && ((nb & MASK_CORNERS) == 8'd0)) ||
                ((nb & MASK_J4_BLOCK) == MASK_J4_BLOCK)) begin
                rank = RANK_JUNCTION4;
            end
        end
        return rank;
    endfunction

endpackage

`default_nettype wire

[design/skeleton_node_classifier_3x3.sv]
// Top level of the skeleton node classifier: counters, 3x3 window, classifier and output queue.
// Depends on snc_pkg and snc_line_store.
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+----------------
//   input   | s_pixel                                 | in        | s_valid/s_ready
//   result  | m_rank, m_last_of_frame                 | out       | m_valid/m_ready
//   config  | cfg_we, cfg_index, cfg_data             | in        | write enable only
//
// One pixel per clock cycle sustained while s_ready is high; a rank is classified in stage 1 and queued.
// The line store is read at acceptance and written back in the following cycle, so the single
// memory read port and write port set the one-pixel-per-cycle figure.
// After reset the line store clears all MAX_WIDTH columns with s_ready low.
// A four-entry result queue keeps s_ready independent of m_ready; s_ready drops when
// the queue and the in-flight pixel would fill it, and while the line store is being cleared.
`default_nettype none

module skeleton_node_classifier_3x3
    import snc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_pixel,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_rank,
    output logic                       m_last_of_frame,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > FRAME_W_W) ? $clog2(MAX_WIDTH + 1) : FRAME_W_W;
    localparam int RW = FRAME_H_W + 1;

    // Configuration registers.
    logic [FRAME_W_W-1:0] frame_width_reg;
    logic [FRAME_H_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_H_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size after saturation.
    logic [WW-1:0] width_ext;
    logic [WW-1:0] width_eff;
    logic [RW-1:0] height_eff;

    always_comb begin
        width_ext = WW'(frame_width_reg);
        if (width_ext < WW'(3)) begin
            width_eff = WW'(3);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        height_eff = (frame_height_reg < FRAME_H_W'(3)) ? RW'(3) : RW'(frame_height_reg);
    end

    // Stage 0: position counters and result decision at acceptance.
    logic          accept;
    logic          store_busy;
    logic [AW-1:0] col_count_reg;
    logic [AW-1:0] col_count_next;
    logic [FRAME_H_W-1:0] row_count_reg;
    logic [FRAME_H_W-1:0] row_count_next;
    logic [WW-1:0] col_ext;
    logic [WW-1:0] col_inc;
    logic [RW-1:0] row_ext;
    logic [RW-1:0] row_inc;
    logic          in_frame;
    logic          is_last;

    always_comb begin
        col_ext  = WW'(col_count_reg);
        row_ext  = RW'(row_count_reg);
        col_inc  = col_ext + WW'(1);
        row_inc  = row_ext + RW'(1);
        in_frame = (row_ext >= RW'(2)) && (row_ext <= height_eff - RW'(1)) &&
                   (col_ext >= WW'(2)) && (col_ext <= width_eff - WW'(1));
        is_last  = (row_ext == height_eff - RW'(1)) && (col_ext == width_eff - WW'(1));
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (col_inc >= width_eff) begin
                col_count_next = '0;
                row_count_next = (row_inc >= height_eff) ? '0 : row_inc[FRAME_H_W-1:0];
            end else begin
                col_count_next = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Stage 1 registers: the accepted pixel waits for its line store read data.
    logic          p1_valid_reg;
    logic          p1_res_reg;
    logic          p1_last_reg;
    logic          p1_px_reg;
    logic [AW-1:0] p1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_res_reg   <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            p1_res_reg   <= accept && in_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_last_reg <= is_last;
            p1_px_reg   <= s_pixel;
            p1_col_reg  <= col_count_reg;
        end
    end

    // Line store: read at acceptance, shifted and written back in stage 1.
    logic [1:0] store_rd;

    snc_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (store_rd),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data ({store_rd[0], p1_px_reg}),
        .busy    (store_busy)
    );

    // Window: bits 5..3 left column, 2..0 center column, top to bottom.
    logic [5:0] window_reg;
    logic [5:0] window_next;
    logic [2:0] col_bits;
    logic [7:0] nb;
    rank_t      p1_rank;

    always_comb begin
        col_bits    = {store_rd, p1_px_reg};
        window_next = p1_valid_reg ? {window_reg[2:0], col_bits} : window_reg;
        nb = {window_reg[5], window_reg[2], col_bits[2], col_bits[1],
              col_bits[0], window_reg[0], window_reg[3], window_reg[4]};
        p1_rank = classify(window_reg[1], nb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else begin
            window_reg <= window_next;
        end
    end

    // Result queue, four entries.
    logic [2:0] fifo_rank_reg [4];
    logic       fifo_last_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] fifo_count_reg;
    logic [2:0] fifo_count_next;
    logic [2:0] occupancy;
    logic       push;
    logic       pop;

    assign push = p1_valid_reg && p1_res_reg;
    assign pop  = m_valid && m_ready;

    always_comb begin
        fifo_count_next = fifo_count_reg;
        if (push && !pop) begin
            fifo_count_next = fifo_count_reg + 3'd1;
        end else if (pop && !push) begin
            fifo_count_next = fifo_count_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            fifo_count_reg <= fifo_count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_rank_reg[wr_ptr_reg] <= p1_rank;
            fifo_last_reg[wr_ptr_reg] <= p1_last_reg;
        end
    end

    // Accept while the line store is not clearing and the queue plus the result in flight leave a free entry.
    assign occupancy = fifo_count_reg + {2'b00, push};
    assign s_ready   = !store_busy && (occupancy < 3'd4);
    assign accept    = s_valid && s_ready;

    assign m_valid         = (fifo_count_reg != 3'd0);
    assign m_rank          = fifo_rank_reg[rd_ptr_reg];
    assign m_last_of_frame = fifo_last_reg[rd_ptr_reg];

    // The queue never holds more than four results.
    a_fifo_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count_reg <= 3'd4)
        else $error("result queue overflow");

    // A frame-end flag only rides on a transaction that produces a result.
    a_last_needs_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_last_reg) |-> p1_res_reg)
        else $error("last_of_frame on a pixel without result");

    // Every accepted pixel reaches stage 1 on the next cycle.
    a_stage1_follows : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted pixel lost before stage 1");

    // Column count stays inside the line store.
    a_col_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_count_reg) < WW'(MAX_WIDTH))
        else $error("column count beyond line store depth");

endmodule

`default_nettype wire

[design/snc_line_store.sv]
// Two-row line store: one synchronous memory holding the upper and middle row bits per column.
// Depends on snc_pkg; clears itself after reset, one column per cycle.
`default_nettype none

module snc_line_store
    import snc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [1:0]    rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [1:0]    wr_data,
    output logic               busy
);

    // Bit 1 is the upper row, bit 0 the middle row.
    logic [1:0]    line_mem [MAX_WIDTH];
    logic [1:0]    rd_data_reg;
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    // Clearing sweep after reset.
    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            if (clr_addr_reg == AW'(MAX_WIDTH - 1)) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            line_mem[clr_addr_reg] <= 2'b00;
        end else if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

    // The user side must stay off the memory while it is being cleared.
    a_no_read_while_clearing : assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !rd_en)
        else $error("line store read during clearing pass");

    a_no_write_while_clearing : assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !wr_en)
        else $error("line store write during clearing pass");

    // A read and a write in one cycle never target the same column.
    a_no_same_column : assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("line store read and write collide on one column");

endmodule

`default_nettype wire

[tb/skeleton_node_classifier_3x3_test.sv]
// Self-checking testbench for skeleton_node_classifier_3x3: pixel stream in, node ranks out.
// Depends on snc_pkg for the rank codes, register indexes and port widths.
// Directed 3x3 shapes come first, then frame-size phases with random pixel content.
module skeleton_node_classifier_3x3_test;
    timeunit 1ns;
    timeprecision 1ps;
    import snc_pkg::*;

    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int RANDOM_PIXELS = 1550;
    localparam int WIDE_PIXELS   = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_ERRORS  = 10;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Neighbor masks, bit 7 top-left and then clockwise to bit 0 on the left.
    localparam bit [7:0] EDGE_SET    = 8'b0101_0101;
    localparam bit [7:0] CORNER_SET  = 8'b1010_1010;
    localparam bit [7:0] TIP_HIT     = 8'b0100_0000;
    localparam bit [7:0] TIP_MISS    = 8'b0001_1111;
    localparam bit [7:0] FORK_HIT    = 8'b1010_0100;
    localparam bit [7:0] FORK_MISS_A = 8'b0101_0001;
    localparam bit [7:0] FORK_MISS_B = 8'b0100_1010;
    localparam bit [7:0] TEE_HIT     = 8'b0001_0101;
    localparam bit [7:0] LOWER_BLOCK = 8'b0001_1100;

    typedef struct packed {
        rank_t rank;
        logic  last;
    } rank_item_t;

    // One 3x3 frame in raster order, MSB first, with the rank of its single interior pixel.
    typedef struct packed {
        logic [8:0] picture;
        rank_t      rank;
    } shape_t;

    shape_t shapes [3] = '{
        '{9'b010_101_010, RANK_HOLLOW},
        '{9'b000_010_000, RANK_ENDPOINT},
        '{9'b010_111_010, RANK_JUNCTION4}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_pixel   = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [2:0]            m_rank;
    logic                  m_last_of_frame;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the block: line stores, window, raster position and frame size.
    bit                   line_upper [LINE_DEPTH];
    bit                   line_middle [LINE_DEPTH];
    bit [5:0]             window_bits = '0;
    int unsigned          next_col    = 0;
    int unsigned          next_row    = 0;
    logic [FRAME_W_W-1:0] width_reg   = FRAME_WIDTH_RST;
    logic [FRAME_H_W-1:0] height_reg  = FRAME_HEIGHT_RST;
    rank_item_t           expected_ranks [$];

    // Directed frames carry a typed rank that replaces the computed one.
    bit    pin_on   = 1'b0;
    rank_t pin_rank = RANK_NONE;

    int unsigned pixels_sent    = 0;
    int unsigned ranks_checked  = 0;
    int unsigned frames_closed  = 0;
    int unsigned mismatch_count = 0;
    int unsigned phases_run     = 0;
    int unsigned burst_left     = 0;
    int unsigned rank_seen [8];
    bit          ready_level    = 1'b0;
    int unsigned ready_run      = 0;

    skeleton_node_classifier_3x3 dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rank          (m_rank),
        .m_last_of_frame (m_last_of_frame),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Effective frame size after saturation.
    function automatic int unsigned live_width();
        if (width_reg < 3) return 3;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned live_height();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    // Rank of a window: off centers can only be a hollow cross, on centers go through
    // the rotated hit-or-miss tests and fall back to the four-way and branch cases.
    function automatic rank_t rank_of_window(input bit center, input bit [7:0] nb);
        bit [7:0] rot;
        rot = nb;
        if (!center) return ((nb & EDGE_SET) == EDGE_SET) ? RANK_HOLLOW : RANK_NONE;
        if (nb == 8'h00) return RANK_ENDPOINT;
        for (int s = 0; s < 8; s++) begin
            if ((rot & TIP_HIT) == TIP_HIT && (rot & TIP_MISS) == 8'h00) return RANK_ENDPOINT;
            if ((rot & FORK_HIT) == FORK_HIT &&
                ((rot & FORK_MISS_A) == 8'h00 || (rot & FORK_MISS_B) == 8'h00))
                return RANK_JUNCTION3;
            if ((rot & TEE_HIT) == TEE_HIT && (rot & FORK_MISS_B) == 8'h00)
                return RANK_JUNCTION3;
            rot = {rot[6:0], rot[7]};
        end
        if (((nb & CORNER_SET) == CORNER_SET && (nb & EDGE_SET) == 8'h00) ||
            ((nb & EDGE_SET) == EDGE_SET && (nb & CORNER_SET) == 8'h00) ||
            (nb & LOWER_BLOCK) == LOWER_BLOCK)
            return RANK_JUNCTION4;
        return RANK_BRANCH;
    endfunction

    // Advance the shadow by one accepted pixel and queue the rank it completes, if any.
    task automatic predict_pixel(input bit px);
        int unsigned w, h, c, r;
        bit          up, mid;
        bit [2:0]    col, left, cen;
        bit [7:0]    nb;
        rank_item_t  item;
        w   = live_width();
        h   = live_height();
        c   = next_col;
        r   = next_row;
        up  = line_upper[c];
        mid = line_middle[c];
        line_upper[c]  = mid;
        line_middle[c] = px;
        col  = {up, mid, px};
        left = window_bits[5:3];
        cen  = window_bits[2:0];
        if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
            nb = {left[2], cen[2], col[2], col[1], col[0], cen[0], left[0], left[1]};
            item.rank = rank_of_window(cen[1], nb);
            item.last = (r == h - 1 && c == w - 1);
            if (pin_on) item.rank = pin_rank;
            expected_ranks = {expected_ranks, item};
            if (item.last) frames_closed++;
        end
        window_bits = {cen, col};
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic report_mismatch(input string what, input logic [2:0] exp_rank,
                                   input logic exp_last);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display({"MISMATCH %0d at %0t ns: %s: expected rank %0d last %0b, ",
                      "got rank %0d last %0b"},
                     mismatch_count, $time, what, exp_rank, exp_last, m_rank, m_last_of_frame);
    endtask

    task automatic check_rank();
        rank_item_t oldest;
        ranks_checked++;
        if (!$isunknown(m_rank)) rank_seen[m_rank]++;
        if (expected_ranks.size() == 0) begin
            report_mismatch("rank with nothing pending", 3'bx, 1'bx);
        end else begin
            oldest = expected_ranks.pop_front();
            if (m_rank !== oldest.rank || m_last_of_frame !== oldest.last)
                report_mismatch("wrong rank transaction", oldest.rank, oldest.last);
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready === 1'b1) predict_pixel(s_pixel);
            if (m_valid === 1'b1 && m_ready) check_rank();
        end
    end

    // Receiver: alternating ready and stall runs, now and then a long run without stalls.
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_level = ~ready_level;
            if (ready_level)
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200)
                                                        : $urandom_range(1, 16);
            else
                ready_run = $urandom_range(1, 6);
        end
        ready_run = ready_run - 1;
        m_ready <= ready_level;
    end

    // Sender: one pixel transaction, in bursts with random gaps between them.
    task automatic send_pixel(input logic px);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(50, 300);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 8);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        burst_left--;
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Register write; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_FRAME_WIDTH) width_reg = data[FRAME_W_W-1:0];
        else if (idx == CFG_FRAME_HEIGHT) height_reg = data[FRAME_H_W-1:0];
        @(negedge aclk);
    endtask

    // Stop sending and wait until every pending rank has come out and the pipe is empty.
    task automatic drain();
        s_valid   <= 1'b0;
        burst_left = 0;
        while (expected_ranks.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        phases_run++;
    endtask

    // New frame size for a random phase, mostly small, sometimes saturating or huge.
    task automatic pick_frame_size();
        int unsigned pick;
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)      write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(3, 12)));
            else if (pick < 16) write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(0, 2)));
            else if (pick < 18) write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(13, 64)));
            else                write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(0, 16'hFFFF)));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)      write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(3, 10)));
            else if (pick < 16) write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 2)));
            else if (pick < 18) write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
            else                write_reg(CFG_FRAME_HEIGHT, 16'($urandom_range(0, 16'hFFFF)));
        end
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      16'($urandom_range(0, 16'hFFFF)));
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned density, span, closed_before, random_goal;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Width 0 and height 1 both saturate to the smallest 3x3 frame.
        write_reg(CFG_FRAME_WIDTH, 16'd0);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        cfg_we <= 1'b0;

        // Each shape is one whole frame whose only interior pixel gets the typed rank.
        foreach (shapes[i]) begin
            for (int p = 8; p >= 0; p--) begin
                pin_on   = (p == 0);
                pin_rank = shapes[i].rank;
                send_pixel(shapes[i].picture[p]);
            end
        end
        pin_on = 1'b0;

        // Narrow and as tall as the register allows; the frame never closes.
        drain();
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        cfg_we <= 1'b0;
        repeat (120) send_pixel($urandom_range(0, 1));

        // Park at the start of the last row, then widen past the line store depth
        // and send a short run at the saturated width.
        drain();
        write_reg(CFG_FRAME_WIDTH, 16'd4);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        cfg_we <= 1'b0;
        while (!(next_row == 2 && next_col == 0)) send_pixel($urandom_range(0, 1));
        drain();
        write_reg(CFG_FRAME_WIDTH, 16'h0FFF);
        cfg_we <= 1'b0;
        repeat (WIDE_PIXELS) send_pixel($urandom_range(0, 1));

        // Random phases; sizes change between them, often in the middle of a frame.
        random_goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < random_goal) begin
            drain();
            pick_frame_size();
            density = $urandom_range(1, 9);
            if (live_width() * live_height() <= 400 && $urandom_range(0, 3) == 0) begin
                closed_before = frames_closed;
                while (frames_closed == closed_before)
                    send_pixel($urandom_range(0, 9) < density);
            end else begin
                span = $urandom_range(20, 160);
                repeat (span) send_pixel($urandom_range(0, 9) < density);
            end
        end
        drain();

        $display("Checked %0d ranks from %0d pixels over %0d size phases, %0d frame ends.",
                 ranks_checked, pixels_sent, phases_run, frames_closed);
        $display({"Ranks seen: none %0d, endpoint %0d, branch %0d, junction3 %0d, ",
                  "junction4 %0d, hollow %0d."},
                 rank_seen[0], rank_seen[1], rank_seen[2], rank_seen[3], rank_seen[4],
                 rank_seen[5]);
        if (mismatch_count == 0 && expected_ranks.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard limit on the run, well beyond the slowest legal schedule.
    initial begin
        #4_000_000;
        $display("Run limit reached with %0d ranks still pending.", expected_ranks.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
